/* rtl/mmu_pkg.sv */
// Shared types, constants and helpers for the matrix multiply unit.
`default_nettype none

package mmu_pkg;

	localparam int MAX_DIM = 8;
	localparam int IDX_W   = $clog2(MAX_DIM);
	localparam int DIM_W   = 4;
	localparam int ADDR_W  = 2 * IDX_W;
	localparam int DATA_W  = 32;
	localparam int DEPTH   = MAX_DIM * MAX_DIM;

	localparam logic [1:0] REQ_LOAD_A  = 2'd0;
	localparam logic [1:0] REQ_LOAD_B  = 2'd1;
	localparam logic [1:0] REQ_COMPUTE = 2'd2;

	localparam logic [1:0] CFG_ROWS_A    = 2'd0;
	localparam logic [1:0] CFG_INNER_DIM = 2'd1;
	localparam logic [1:0] CFG_COLS_B    = 2'd2;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_ISSUE,
		ST_WAIT,
		ST_EMIT
	} seq_state_t;

	typedef struct packed {
		logic              vld;
		logic              first;
		logic              last_k;
		logic [ADDR_W-1:0] a_addr;
		logic [ADDR_W-1:0] b_addr;
	} issue_t;

	typedef struct packed {
		logic             load;
		logic [IDX_W-1:0] row;
		logic [IDX_W-1:0] col;
		logic             last;
	} emit_t;

	function automatic logic [DIM_W-1:0] eff_size(input logic [DIM_W-1:0] r);
		logic [DIM_W-1:0] s;
		if (r == '0)
			s = DIM_W'(1);
		else if (r > DIM_W'(MAX_DIM))
			s = DIM_W'(MAX_DIM);
		else
			s = r;
		return s;
	endfunction

endpackage

`default_nettype wire

/* rtl/matrix_multiply_unit.sv */
// Matrix multiply unit top level: size registers, element memories, result register.
// A load transaction writes one element of A or B. A compute
// transaction emits rows_a*cols_b results and keeps the request side stalled until
// the final result is loaded into the result register, including any time the
// result side stalls. Each product element needs inner_dim passes through the one
// shared multiply-accumulate unit; then the registered memory read, multiply and
// accumulate stages drain and the result is handed over.
// Size registers saturate to 1..8 when used; writes outside the sizes are dropped.
`default_nettype none

module matrix_multiply_unit import mmu_pkg::*; (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              cfg_valid,
	output logic                   cfg_ready,
	input  wire logic [1:0]        cfg_index,
	input  wire logic [DIM_W-1:0]  cfg_data,
	input  wire logic              req_valid,
	output logic                   req_stall,
	input  wire logic [1:0]        req_type,
	input  wire logic [IDX_W-1:0]  row,
	input  wire logic [IDX_W-1:0]  col,
	input  wire logic signed [DATA_W-1:0] value,
	output logic                   rsp_valid,
	input  wire logic              rsp_stall,
	output logic [IDX_W-1:0]       out_row,
	output logic [IDX_W-1:0]       out_col,
	output logic signed [DATA_W-1:0] product,
	output logic                   last
);

	logic [DIM_W-1:0]  rows_a_q, inner_dim_q, cols_b_q;
	logic [DIM_W-1:0]  m, n, p;
	logic              req_acc, busy, out_free, start, wr_a, wr_b;
	logic [DATA_W-1:0] a_mem [DEPTH];
	logic [DATA_W-1:0] b_mem [DEPTH];
	logic [DATA_W-1:0] a_rd_s1, b_rd_s1, acc_q;
	logic              done_q;
	issue_t            issue;
	emit_t             emit;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rows_a_q    <= DIM_W'(2);
			inner_dim_q <= DIM_W'(3);
			cols_b_q    <= DIM_W'(2);
		end else if (cfg_valid) begin
			unique case (cfg_index)
				CFG_ROWS_A:    rows_a_q    <= cfg_data;
				CFG_INNER_DIM: inner_dim_q <= cfg_data;
				CFG_COLS_B:    cols_b_q    <= cfg_data;
				default:       ;
			endcase
		end
	end

	assign m = eff_size(rows_a_q);
	assign n = eff_size(inner_dim_q);
	assign p = eff_size(cols_b_q);

	assign req_stall = busy;
	assign req_acc   = req_valid && !busy;
	assign start     = req_acc && (req_type == REQ_COMPUTE);
	assign wr_a      = req_acc && (req_type == REQ_LOAD_A) &&
	                   (DIM_W'({1'b0, row}) < m) && (DIM_W'({1'b0, col}) < n);
	assign wr_b      = req_acc && (req_type == REQ_LOAD_B) &&
	                   (DIM_W'({1'b0, row}) < n) && (DIM_W'({1'b0, col}) < p);
	assign out_free  = !rsp_valid || !rsp_stall;

	always_ff @(posedge clk) begin
		if (wr_a)
			a_mem[{row, col}] <= value;
		a_rd_s1 <= a_mem[issue.a_addr];
	end

	always_ff @(posedge clk) begin
		if (wr_b)
			b_mem[{row, col}] <= value;
		b_rd_s1 <= b_mem[issue.b_addr];
	end

	mmu_seq u_seq (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (start),
		.m        (m),
		.n        (n),
		.p        (p),
		.mac_done (done_q),
		.out_free (out_free),
		.busy     (busy),
		.issue    (issue),
		.emit     (emit)
	);

	mmu_mac u_mac (
		.clk     (clk),
		.arst_n  (arst_n),
		.vld     (issue.vld),
		.first   (issue.first),
		.last_k  (issue.last_k),
		.a_rd_s1 (a_rd_s1),
		.b_rd_s1 (b_rd_s1),
		.acc_q   (acc_q),
		.done_q  (done_q)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			rsp_valid <= 1'b0;
		else if (emit.load)
			rsp_valid <= 1'b1;
		else if (!rsp_stall)
			rsp_valid <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (emit.load) begin
			out_row <= emit.row;
			out_col <= emit.col;
			product <= acc_q;
			last    <= emit.last;
		end
	end

	// a compute transaction locks out the request side
	a_start_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start |=> req_stall)
		else $error("request side open right after compute start");

	// the final result hands the block back to idle
	a_last_idle: assert property (@(posedge clk) disable iff (!arst_n)
		emit.load && emit.last |=> !req_stall)
		else $error("block still busy after final result");

	// results are only produced while a compute runs
	a_emit_busy: assert property (@(posedge clk) disable iff (!arst_n)
		emit.load |-> busy && done_q == 1'b0 && out_free)
		else $error("result loaded outside a compute");

	// no new accumulation is issued while a finished sum waits
	a_done_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> !issue.vld)
		else $error("issue overlaps finished sum");

endmodule

`default_nettype wire

/* rtl/mmu_mac.sv */
// Shared multiply-accumulate unit: multiply stage, then accumulate stage.
`default_nettype none

module mmu_mac import mmu_pkg::*; (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              vld,
	input  wire logic              first,
	input  wire logic              last_k,
	input  wire logic [DATA_W-1:0] a_rd_s1,
	input  wire logic [DATA_W-1:0] b_rd_s1,
	output logic      [DATA_W-1:0] acc_q,
	output logic                   done_q
);

	logic              vld_s1, first_s1, last_s1;
	logic              vld_s2, first_s2, last_s2;
	logic [DATA_W-1:0] prod_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			done_q <= 1'b0;
		end else begin
			vld_s1 <= vld;
			vld_s2 <= vld_s1;
			done_q <= vld_s2 && last_s2;
		end
	end

	always_ff @(posedge clk) begin
		first_s1 <= first;
		last_s1  <= last_k;
		first_s2 <= first_s1;
		last_s2  <= last_s1;
		prod_s2  <= DATA_W'(a_rd_s1 * b_rd_s1);
		if (vld_s2)
			acc_q <= first_s2 ? prod_s2 : acc_q + prod_s2;
	end

endmodule

`default_nettype wire

/* rtl/mmu_seq.sv */
// Sequencer: walks rows, columns and the inner index of one compute.
`default_nettype none

module mmu_seq import mmu_pkg::*; (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             start,
	input  wire logic [DIM_W-1:0] m,
	input  wire logic [DIM_W-1:0] n,
	input  wire logic [DIM_W-1:0] p,
	input  wire logic             mac_done,
	input  wire logic             out_free,
	output logic                  busy,
	output issue_t                issue,
	output emit_t                 emit
);

	seq_state_t       state_q, state_d;
	logic [IDX_W-1:0] i_q, j_q, k_q;
	logic             k_last, j_last, i_last;

	assign k_last = (DIM_W'({1'b0, k_q}) + DIM_W'(1)) == n;
	assign j_last = (DIM_W'({1'b0, j_q}) + DIM_W'(1)) == p;
	assign i_last = (DIM_W'({1'b0, i_q}) + DIM_W'(1)) == m;

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE:  if (start) state_d = ST_ISSUE;
			ST_ISSUE: if (k_last) state_d = ST_WAIT;
			ST_WAIT:  if (mac_done) state_d = ST_EMIT;
			ST_EMIT:  if (out_free) state_d = (i_last && j_last) ? ST_IDLE : ST_ISSUE;
			default:  state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		busy        = 1'b1;
		issue.vld   = 1'b0;
		emit.load   = 1'b0;
		unique case (state_q)
			ST_IDLE:  busy = 1'b0;
			ST_ISSUE: issue.vld = 1'b1;
			ST_WAIT:  ;
			ST_EMIT:  emit.load = out_free;
			default:  busy = 1'b0;
		endcase
		issue.first  = (k_q == '0);
		issue.last_k = k_last;
		issue.a_addr = {i_q, k_q};
		issue.b_addr = {k_q, j_q};
		emit.row     = i_q;
		emit.col     = j_q;
		emit.last    = i_last && j_last;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			i_q     <= '0;
			j_q     <= '0;
			k_q     <= '0;
		end else begin
			state_q <= state_d;
			if (state_q == ST_IDLE && start) begin
				i_q <= '0;
				j_q <= '0;
				k_q <= '0;
			end
			if (state_q == ST_ISSUE)
				k_q <= k_last ? '0 : k_q + IDX_W'(1);
			if (state_q == ST_EMIT && out_free) begin
				if (j_last) begin
					j_q <= '0;
					i_q <= i_q + IDX_W'(1);
				end else begin
					j_q <= j_q + IDX_W'(1);
				end
			end
		end
	end

endmodule

`default_nettype wire

/* tb/tb_matrix_multiply_unit.sv */
// Self-checking testbench for matrix_multiply_unit: random loads and products.
`timescale 1ns / 100ps

module tb_matrix_multiply_unit import mmu_pkg::*; ();

	localparam logic [1:0] REQ_UNUSED = 2'd3;
	localparam logic [1:0] CFG_UNUSED = 2'd3;
	localparam int RAND_ITEMS    = 400;
	localparam int SETTLE_CYCLES = 16;
	localparam int TAIL_CYCLES   = 64;
	localparam int HOLD_CYCLES   = 300;
	localparam int STALL_LIMIT   = 4000;
	localparam int MAX_REPORTS   = 10;

	typedef struct packed {
		logic [IDX_W-1:0]        row;
		logic [IDX_W-1:0]        col;
		logic signed [DATA_W-1:0] value;
		logic                    last;
	} elem_t;

	class matmul_scoreboard;
		logic [DATA_W-1:0] a_mem [DEPTH];
		logic [DATA_W-1:0] b_mem [DEPTH];
		bit                a_set [DEPTH];
		bit                b_set [DEPTH];
		logic [DIM_W-1:0]  size_reg [3];
		elem_t             awaited [$];
		int unsigned loads, computes, ignored, reg_writes, results, errors;

		function new();
			size_reg[CFG_ROWS_A]    = 4'd2;
			size_reg[CFG_INNER_DIM] = 4'd3;
			size_reg[CFG_COLS_B]    = 4'd2;
		endfunction

		function int unsigned eff_dim(logic [1:0] idx);
			logic [DIM_W-1:0] r;
			r = size_reg[idx];
			if (r == 0)
				return 1;
			return (r > MAX_DIM) ? MAX_DIM : r;
		endfunction

		function int unsigned pending();
			return awaited.size();
		endfunction

		function void note_size_write(logic [1:0] idx, logic [DIM_W-1:0] data);
			reg_writes++;
			if (idx == CFG_ROWS_A || idx == CFG_INNER_DIM || idx == CFG_COLS_B)
				size_reg[idx] = data;
		endfunction

		function void note_request(logic [1:0] kind, logic [IDX_W-1:0] r,
				logic [IDX_W-1:0] c, logic [DATA_W-1:0] v);
			int unsigned m, n, p;
			logic [DATA_W-1:0] acc;
			elem_t e;
			m = eff_dim(CFG_ROWS_A);
			n = eff_dim(CFG_INNER_DIM);
			p = eff_dim(CFG_COLS_B);
			case (kind)
				REQ_LOAD_A: begin
					if (r < m && c < n) begin
						a_mem[r * MAX_DIM + c] = v;
						a_set[r * MAX_DIM + c] = 1'b1;
						loads++;
					end else
						ignored++;
				end
				REQ_LOAD_B: begin
					if (r < n && c < p) begin
						b_mem[r * MAX_DIM + c] = v;
						b_set[r * MAX_DIM + c] = 1'b1;
						loads++;
					end else
						ignored++;
				end
				REQ_COMPUTE: begin
					computes++;
					for (int i = 0; i < m; i++)
						for (int j = 0; j < p; j++) begin
							acc = '0;
							for (int k = 0; k < n; k++)
								acc += a_mem[i * MAX_DIM + k] * b_mem[k * MAX_DIM + j];
							e.row   = i[IDX_W-1:0];
							e.col   = j[IDX_W-1:0];
							e.value = acc;
							e.last  = (i + 1 == m) && (j + 1 == p);
							awaited.push_back(e);
						end
				end
				default: ignored++;
			endcase
		endfunction

		function void check_element(logic [IDX_W-1:0] r, logic [IDX_W-1:0] c,
				logic signed [DATA_W-1:0] v, logic l);
			elem_t want;
			results++;
			if (awaited.size() == 0) begin
				errors++;
				if (errors <= MAX_REPORTS)
					$display("%0t unexpected result: row %0d col %0d product %0d last %0b",
						$time, r, c, v, l);
				return;
			end
			want = awaited.pop_front();
			if (r !== want.row || c !== want.col || v !== want.value || l !== want.last) begin
				errors++;
				if (errors <= MAX_REPORTS)
					$display({"%0t mismatch: expected (%0d,%0d) %0d last %0b, ",
						"got (%0d,%0d) %0d last %0b"},
						$time, want.row, want.col, want.value, want.last, r, c, v, l);
			end
		endfunction

		function void close_out();
			if (awaited.size() != 0) begin
				errors++;
				$display("%0d expected result elements never arrived", awaited.size());
			end
		endfunction
	endclass

	logic                     clk;
	logic                     arst_n    = 1'b0;
	logic                     cfg_valid = 1'b0;
	logic                     cfg_ready;
	logic [1:0]               cfg_index = '0;
	logic [DIM_W-1:0]         cfg_data  = '0;
	logic                     req_valid = 1'b0;
	logic                     req_stall;
	logic [1:0]               req_type  = '0;
	logic [IDX_W-1:0]         row       = '0;
	logic [IDX_W-1:0]         col       = '0;
	logic signed [DATA_W-1:0] value     = '0;
	logic                     rsp_valid;
	logic                     rsp_stall = 1'b0;
	logic [IDX_W-1:0]         out_row;
	logic [IDX_W-1:0]         out_col;
	logic signed [DATA_W-1:0] product;
	logic                     last;

	matmul_scoreboard sb = new();
	bit          hold_pending = 1'b0;
	bit          tx_quiet     = 1'b0;
	bit          rx_quiet     = 1'b0;
	int unsigned rx_wait      = 0;

	matrix_multiply_unit dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.req_type  (req_type),
		.row       (row),
		.col       (col),
		.value     (value),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.out_row   (out_row),
		.out_col   (out_col),
		.product   (product),
		.last      (last)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// result side: per-transaction stall draw, plus one long hold on request
	always @(posedge clk) begin
		if (arst_n && rsp_valid && !rsp_stall) begin
			sb.check_element(out_row, out_col, product, last);
			if ($urandom_range(0, 29) == 0)
				rx_quiet = !rx_quiet;
			rx_wait = rx_quiet ? 0 : $urandom_range(0, 17);
		end
		if (hold_pending) begin
			hold_pending = 1'b0;
			rx_wait += HOLD_CYCLES;
		end
		if (rx_wait != 0) begin
			rsp_stall <= 1'b1;
			rx_wait--;
		end else
			rsp_stall <= 1'b0;
	end

	initial begin : watchdog
		int unsigned idle;
		idle = 0;
		while (idle < STALL_LIMIT) begin
			@(posedge clk);
			if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) ||
					(cfg_valid && cfg_ready))
				idle = 0;
			else
				idle++;
		end
		$display("timeout: no transaction for %0d cycles", STALL_LIMIT);
		$display("FAIL matrix_multiply_unit");
		$finish;
	end

	function automatic logic [DATA_W-1:0] rand_value();
		case ($urandom_range(0, 9))
			0: return 32'h8000_0000;
			1: return 32'h7fff_ffff;
			2: return 32'hffff_ffff;
			3: return 32'h0000_0000;
			default: return $urandom;
		endcase
	endfunction

	function automatic logic [DIM_W-1:0] rand_size();
		if ($urandom_range(0, 4) == 0)
			return DIM_W'($urandom_range(0, 15));
		return DIM_W'($urandom_range(1, 4));
	endfunction

	task automatic send_req(logic [1:0] kind, logic [IDX_W-1:0] r, logic [IDX_W-1:0] c,
			logic [DATA_W-1:0] v);
		int unsigned gap;
		if ($urandom_range(0, 29) == 0)
			tx_quiet = !tx_quiet;
		gap = tx_quiet ? 0 : $urandom_range(0, 17);
		if (gap != 0) begin
			req_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req_valid <= 1'b1;
		req_type  <= kind;
		row       <= r;
		col       <= c;
		value     <= v;
		do @(posedge clk); while (req_stall);
		sb.note_request(kind, r, c, v);
	endtask

	task automatic wait_drained();
		req_valid <= 1'b0;
		do @(posedge clk); while (sb.pending() != 0);
	endtask

	task automatic write_reg(logic [1:0] idx, logic [DIM_W-1:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		do @(posedge clk); while (!cfg_ready);
		sb.note_size_write(idx, data);
	endtask

	task automatic set_sizes(logic [DIM_W-1:0] ra, logic [DIM_W-1:0] id,
			logic [DIM_W-1:0] cb, bit poke_unused);
		wait_drained();
		repeat (SETTLE_CYCLES) @(posedge clk);
		write_reg(CFG_ROWS_A, ra);
		write_reg(CFG_INNER_DIM, id);
		write_reg(CFG_COLS_B, cb);
		if (poke_unused)
			write_reg(CFG_UNUSED, DIM_W'($urandom));
		cfg_valid <= 1'b0;
	endtask

	// make sure no product reads an element that was never loaded
	task automatic fill_missing();
		int unsigned m, n, p;
		m = sb.eff_dim(CFG_ROWS_A);
		n = sb.eff_dim(CFG_INNER_DIM);
		p = sb.eff_dim(CFG_COLS_B);
		for (int i = 0; i < m; i++)
			for (int k = 0; k < n; k++)
				if (!sb.a_set[i * MAX_DIM + k])
					send_req(REQ_LOAD_A, IDX_W'(i), IDX_W'(k), rand_value());
		for (int k = 0; k < n; k++)
			for (int j = 0; j < p; j++)
				if (!sb.b_set[k * MAX_DIM + j])
					send_req(REQ_LOAD_B, IDX_W'(k), IDX_W'(j), rand_value());
	endtask

	task automatic send_noise();
		int unsigned m, n, p;
		logic [IDX_W-1:0] r, c;
		m = sb.eff_dim(CFG_ROWS_A);
		n = sb.eff_dim(CFG_INNER_DIM);
		p = sb.eff_dim(CFG_COLS_B);
		r = IDX_W'($urandom);
		c = IDX_W'($urandom);
		if ($urandom_range(0, 1) && (m < MAX_DIM || n < MAX_DIM)) begin
			if (m < MAX_DIM)
				r = IDX_W'($urandom_range(m, MAX_DIM - 1));
			else
				c = IDX_W'($urandom_range(n, MAX_DIM - 1));
			send_req(REQ_LOAD_A, r, c, rand_value());
		end else if ($urandom_range(0, 1) && (n < MAX_DIM || p < MAX_DIM)) begin
			if (n < MAX_DIM)
				r = IDX_W'($urandom_range(n, MAX_DIM - 1));
			else
				c = IDX_W'($urandom_range(p, MAX_DIM - 1));
			send_req(REQ_LOAD_B, r, c, rand_value());
		end else
			send_req(REQ_UNUSED, r, c, rand_value());
	endtask

	task automatic run_product();
		int unsigned m, n, p, count;
		m = sb.eff_dim(CFG_ROWS_A);
		n = sb.eff_dim(CFG_INNER_DIM);
		p = sb.eff_dim(CFG_COLS_B);
		count = $urandom_range(0, 6);
		repeat (count) begin
			if ($urandom_range(0, 5) == 0)
				send_noise();
			else if ($urandom_range(0, 1))
				send_req(REQ_LOAD_A, IDX_W'($urandom_range(0, m - 1)),
					IDX_W'($urandom_range(0, n - 1)), rand_value());
			else
				send_req(REQ_LOAD_B, IDX_W'($urandom_range(0, n - 1)),
					IDX_W'($urandom_range(0, p - 1)), rand_value());
		end
		fill_missing();
		send_req(REQ_COMPUTE, IDX_W'($urandom), IDX_W'($urandom), rand_value());
	endtask

	// hold the result side while loads keep coming, then drain completely
	task automatic squeeze_output();
		int unsigned m, n;
		m = sb.eff_dim(CFG_ROWS_A);
		n = sb.eff_dim(CFG_INNER_DIM);
		fill_missing();
		hold_pending = 1'b1;
		send_req(REQ_COMPUTE, IDX_W'($urandom), IDX_W'($urandom), rand_value());
		repeat (6)
			send_req(REQ_LOAD_A, IDX_W'($urandom_range(0, m - 1)),
				IDX_W'($urandom_range(0, n - 1)), rand_value());
		wait_drained();
	endtask

	initial begin : stimulus
		int unsigned base, phase, seqs;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset sizes 2x3x2, extreme values
		send_req(REQ_LOAD_A, 0, 0, 32'h7fff_ffff);
		send_req(REQ_LOAD_A, 0, 1, 32'h8000_0000);
		send_req(REQ_LOAD_A, 0, 2, 32'hffff_ffff);
		send_req(REQ_LOAD_A, 1, 0, 32'h0000_0001);
		send_req(REQ_LOAD_A, 1, 1, 32'h0000_0000);
		send_req(REQ_LOAD_A, 1, 2, 32'h7fff_ffff);
		send_req(REQ_LOAD_B, 0, 0, 32'h8000_0000);
		send_req(REQ_LOAD_B, 0, 1, 32'hffff_ffff);
		send_req(REQ_LOAD_B, 1, 0, 32'h7fff_ffff);
		send_req(REQ_LOAD_B, 1, 1, 32'hffff_ffff);
		send_req(REQ_LOAD_B, 2, 0, 32'h8000_0000);
		send_req(REQ_LOAD_B, 2, 1, 32'h7fff_ffff);
		send_req(REQ_LOAD_A, 7, 7, 32'h1234_5678);
		send_req(REQ_LOAD_A, 2, 0, 32'hdead_beef);
		send_req(REQ_LOAD_B, 7, 7, 32'h5555_aaaa);
		send_req(REQ_UNUSED, 7, 7, 32'hffff_ffff);
		send_req(REQ_COMPUTE, 7, 7, 32'hffff_ffff);
		// zero size reads as one; stored elements stay put across size changes
		set_sizes(4'd0, 4'd2, 4'd1, 1'b1);
		send_req(REQ_COMPUTE, 0, 0, 32'h0);
		set_sizes(4'd1, 4'd1, 4'd2, 1'b0);
		send_req(REQ_COMPUTE, 3, 4, 32'h0);

		base  = sb.loads + sb.computes;
		phase = 0;
		while (sb.loads + sb.computes < base + RAND_ITEMS) begin
			if (phase == 1)
				set_sizes(4'd9, 4'd15, 4'd8, 1'b1);
			else
				set_sizes(rand_size(), rand_size(), rand_size(), $urandom_range(0, 3) == 0);
			seqs = (phase == 1) ? 2 : $urandom_range(2, 4);
			for (int s = 0; s < seqs; s++) begin
				if (phase == 2 && s == 0)
					squeeze_output();
				else
					run_product();
				if ($urandom_range(0, 3) == 0)
					wait_drained();
			end
			phase++;
		end

		wait_drained();
		repeat (TAIL_CYCLES) @(posedge clk);
		sb.close_out();
		$display("covered %0d loads, %0d products over %0d size settings, %0d ignored requests",
			sb.loads, sb.computes, phase + 3, sb.ignored);
		$display("checked %0d result elements after %0d register writes, %0d errors",
			sb.results, sb.reg_writes, sb.errors);
		if (sb.errors == 0)
			$display("PASS matrix_multiply_unit");
		else
			$display("FAIL matrix_multiply_unit");
		$finish;
	end

endmodule
